### rtl/rph_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Rolling prefix hash package
// Shared widths, codes, reset values and types for the rolling hash block.
// ----------------------------------------------------------------------------
package rph_pkg;

  localparam int unsigned MaxLen  = 4096;
  localparam int unsigned AddrW   = $clog2(MaxLen);
  localparam int unsigned LenW    = $clog2(MaxLen + 1);
  localparam int unsigned DataW   = 60;
  localparam int unsigned RadixW  = 12;
  localparam int unsigned CharW   = 8;
  localparam int unsigned PosW    = 12;
  localparam int unsigned CntW    = $clog2(DataW);

  localparam logic [DataW-1:0]  ModulusReset = 60'd1000000000000000003;
  localparam logic [RadixW-1:0] RadixReset   = 12'd233;

  localparam logic [1:0] ReqAppend = 2'd0;
  localparam logic [1:0] ReqQuery  = 2'd1;
  localparam logic [1:0] ReqClear  = 2'd2;

  localparam logic [1:0] StOk     = 2'd0;
  localparam logic [1:0] StFull   = 2'd1;
  localparam logic [1:0] StBeyond = 2'd2;

  localparam logic CfgModulus = 1'b0;
  localparam logic CfgRadix   = 1'b1;

  // Write beat into the prefix and power stores.
  typedef struct packed {
    logic             we;
    logic [AddrW-1:0] addr;
    logic [DataW-1:0] hash;
    logic [DataW-1:0] power;
  } wr_t;

endpackage

### rtl/rph_mulmod.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Serial modular multiplier
// Computes (x * y) mod m one bit of x at a time, y already below m.
// ----------------------------------------------------------------------------
module rph_mulmod (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     go_i,
  input  logic [rph_pkg::DataW-1:0] x_i,
  input  logic [rph_pkg::DataW-1:0] y_i,
  input  logic [rph_pkg::DataW-1:0] m_i,
  output logic                     done_o,
  output logic [rph_pkg::DataW-1:0] result_o
);

  logic                      run_q, run_d;
  logic                      phase_q, phase_d;
  logic                      done_q, done_d;
  logic [rph_pkg::CntW-1:0]  cnt_q, cnt_d;
  logic [rph_pkg::DataW-1:0] x_q, x_d, y_q, y_d, acc_q, acc_d;
  logic [rph_pkg::DataW:0]   dbl, sum, m_ext;

  assign m_ext = {1'b0, m_i};
  assign dbl   = {acc_q, 1'b0};
  assign sum   = {1'b0, acc_q} + {1'b0, y_q};

  always_comb begin
    run_d   = run_q;
    phase_d = phase_q;
    done_d  = 1'b0;
    cnt_d   = cnt_q;
    x_d     = x_q;
    y_d     = y_q;
    acc_d   = acc_q;
    if (go_i) begin
      run_d   = 1'b1;
      phase_d = 1'b0;
      cnt_d   = rph_pkg::CntW'(rph_pkg::DataW - 1);
      x_d     = x_i;
      y_d     = y_i;
      acc_d   = '0;
    end else if (run_q) begin
      if (!phase_q) begin
        // Doubling stays below twice the modulus, so one subtract reduces it.
        acc_d   = (dbl >= m_ext) ? rph_pkg::DataW'(dbl - m_ext) : dbl[rph_pkg::DataW-1:0];
        phase_d = 1'b1;
      end else begin
        if (x_q[rph_pkg::DataW-1]) begin
          acc_d = (sum >= m_ext) ? rph_pkg::DataW'(sum - m_ext) : sum[rph_pkg::DataW-1:0];
        end
        x_d     = {x_q[rph_pkg::DataW-2:0], 1'b0};
        phase_d = 1'b0;
        if (cnt_q == '0) begin
          run_d  = 1'b0;
          done_d = 1'b1;
        end else begin
          cnt_d = cnt_q - 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_q   <= 1'b0;
      phase_q <= 1'b0;
      done_q  <= 1'b0;
      cnt_q   <= '0;
    end else begin
      run_q   <= run_d;
      phase_q <= phase_d;
      done_q  <= done_d;
      cnt_q   <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    x_q   <= x_d;
    y_q   <= y_d;
    acc_q <= acc_d;
  end

  assign done_o   = done_q;
  assign result_o = acc_q;

endmodule

### rtl/rph_store.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Prefix and power stores
// Two synchronous memories with one write and one registered read each.
// ----------------------------------------------------------------------------
module rph_store (
  input  logic                      clk_i,
  input  rph_pkg::wr_t              wr_i,
  input  logic [rph_pkg::AddrW-1:0] hash_addr_i,
  input  logic [rph_pkg::AddrW-1:0] power_addr_i,
  output logic [rph_pkg::DataW-1:0] hash_o,
  output logic [rph_pkg::DataW-1:0] power_o
);

  logic [rph_pkg::DataW-1:0] hash_mem  [rph_pkg::MaxLen];
  logic [rph_pkg::DataW-1:0] power_mem [rph_pkg::MaxLen];

  always_ff @(posedge clk_i) begin
    if (wr_i.we) begin
      hash_mem[wr_i.addr]  <= wr_i.hash;
      power_mem[wr_i.addr] <= wr_i.power;
    end
    hash_o  <= hash_mem[hash_addr_i];
    power_o <= power_mem[power_addr_i];
  end

endmodule

### rtl/rolling_prefix_hash_table.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Rolling prefix hash table
// Clear, unknown and rejected requests answer in the cycle after start. Appends
// and queries run through the sequencer states; each modular multiply holds
// the sequencer while the shared serial multiplier works (a doubling and an
// add step per bit of x, plus a step to launch and one to see done).
// One item at a time; busy is high while an item is in flight.
// Reset empties the string and loads the default modulus and radix; the
// stores are not cleared. Results are strobed and cannot be held off.
// ----------------------------------------------------------------------------
module rolling_prefix_hash_table (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       start,
  output logic                       busy,
  input  logic [1:0]                 req_type_i,
  input  logic [rph_pkg::CharW-1:0]  char_code_i,
  input  logic [rph_pkg::PosW-1:0]   left_pos_i,
  input  logic [rph_pkg::PosW-1:0]   right_pos_i,
  input  logic                       cfg_we_i,
  input  logic                       cfg_idx_i,
  input  logic [rph_pkg::DataW-1:0]  cfg_data_i,
  output logic                       valid_o,
  output logic [rph_pkg::DataW-1:0]  hash_value_o,
  output logic [1:0]                 status_o
);

  // One-hot sequencer. Appends run the A states, queries the Q states.
  typedef enum logic [13:0] {
    S_IDLE  = 14'b00000000000001,
    S_A_RD  = 14'b00000000000010,
    S_A_RY  = 14'b00000000000100,
    S_A_MH  = 14'b00000000001000,
    S_A_RC  = 14'b00000000010000,
    S_A_ADD = 14'b00000000100000,
    S_A_MP  = 14'b00000001000000,
    S_A_WR  = 14'b00000010000000,
    S_Q_RD1 = 14'b00000100000000,
    S_Q_RD2 = 14'b00001000000000,
    S_Q_RH  = 14'b00010000000000,
    S_Q_RP  = 14'b00100000000000,
    S_Q_MS  = 14'b01000000000000,
    S_Q_FIN = 14'b10000000000000
  } state_e;

  state_e state_q, state_d;

  logic [rph_pkg::DataW-1:0]  modulus_q, modulus_d;
  logic [rph_pkg::RadixW-1:0] radix_q, radix_d;
  logic [rph_pkg::LenW-1:0]   len_q, len_d;
  logic                       launched_q, launched_d;
  logic                       valid_q, valid_d;
  logic [rph_pkg::DataW-1:0]  res_q, res_d;
  logic [1:0]                 st_q, st_d;

  // Working registers of the item in flight.
  logic [rph_pkg::CharW-1:0]  char_q, char_d;
  logic [rph_pkg::PosW-1:0]   lp_q, lp_d;
  logic [rph_pkg::DataW-1:0]  a_q, a_d;   // previous prefix hash, or raw H(r+1)
  logic [rph_pkg::DataW-1:0]  b_q, b_d;   // previous power, or raw power
  logic [rph_pkg::DataW-1:0]  c_q, c_d;   // H(l), or reduced char
  logic [rph_pkg::DataW-1:0]  h_q, h_d;   // running hash result
  logic [rph_pkg::DataW-1:0]  k_q, k_d;   // reduced radix for appends

  logic [rph_pkg::DataW-1:0]  m_eff;
  logic                       eng_go, eng_done;
  logic [rph_pkg::DataW-1:0]  eng_x, eng_y, eng_res;
  logic [rph_pkg::AddrW-1:0]  hash_addr, power_addr;
  logic [rph_pkg::DataW-1:0]  hash_rd, power_rd;
  rph_pkg::wr_t               wr;
  logic                       accept;
  logic [rph_pkg::LenW-1:0]   len_m1;
  logic [rph_pkg::DataW:0]    add_sum;

  // A modulus below two is treated as two.
  assign m_eff  = (modulus_q < rph_pkg::DataW'(2)) ? rph_pkg::DataW'(2) : modulus_q;
  assign accept = start && (state_q == S_IDLE);
  assign busy   = (state_q != S_IDLE);
  assign len_m1 = len_q - 1'b1;
  assign add_sum = {1'b0, h_q} + {1'b0, c_q};

  // Reads issued while idle land in the first state of the item.
  always_comb begin
    if (state_q == S_Q_RD1) begin
      hash_addr  = rph_pkg::AddrW'(lp_q - 1'b1);
      power_addr = rph_pkg::AddrW'(lp_q - 1'b1);
    end else if (req_type_i == rph_pkg::ReqAppend) begin
      hash_addr  = len_m1[rph_pkg::AddrW-1:0];
      power_addr = len_m1[rph_pkg::AddrW-1:0];
    end else begin
      hash_addr  = rph_pkg::AddrW'(right_pos_i);
      power_addr = rph_pkg::AddrW'(right_pos_i - left_pos_i);
    end
  end

  // Operand selection for the shared multiplier. Reductions use y = 1.
  always_comb begin
    eng_x = '0;
    eng_y = rph_pkg::DataW'(1);
    case (state_q)
      S_A_RY:  eng_x = rph_pkg::DataW'(radix_q);
      S_A_MH:  begin
        eng_x = a_q;
        eng_y = k_q;
      end
      S_A_RC:  eng_x = rph_pkg::DataW'(char_q);
      S_A_MP:  begin
        eng_x = b_q;
        eng_y = k_q;
      end
      S_Q_RH:  eng_x = a_q;
      S_Q_RP:  eng_x = b_q;
      S_Q_MS:  begin
        eng_x = c_q;
        eng_y = b_q;
      end
      default: eng_x = '0;
    endcase
  end

  always_comb begin
    state_d    = state_q;
    modulus_d  = modulus_q;
    radix_d    = radix_q;
    len_d      = len_q;
    launched_d = launched_q;
    valid_d    = 1'b0;
    res_d      = res_q;
    st_d       = st_q;
    char_d     = char_q;
    lp_d       = lp_q;
    a_d        = a_q;
    b_d        = b_q;
    c_d        = c_q;
    h_d        = h_q;
    k_d        = k_q;
    eng_go     = 1'b0;
    wr.we      = 1'b0;
    wr.addr    = len_q[rph_pkg::AddrW-1:0];
    wr.hash    = h_q;
    wr.power   = eng_res;

    if (cfg_we_i) begin
      if (cfg_idx_i == rph_pkg::CfgModulus) begin
        modulus_d = cfg_data_i;
      end else begin
        radix_d = cfg_data_i[rph_pkg::RadixW-1:0];
      end
    end

    // Multiplier states share one launch-and-wait pattern.
    if (state_q == S_A_RY || state_q == S_A_MH || state_q == S_A_RC ||
        state_q == S_A_MP || state_q == S_Q_RH || state_q == S_Q_RP ||
        state_q == S_Q_MS) begin
      if (!launched_q) begin
        eng_go     = 1'b1;
        launched_d = 1'b1;
      end
    end

    case (state_q)
      S_IDLE: begin
        if (accept) begin
          char_d = char_code_i;
          lp_d   = left_pos_i;
          res_d  = '0;
          st_d   = rph_pkg::StOk;
          case (req_type_i)
            rph_pkg::ReqAppend: begin
              if (len_q == rph_pkg::LenW'(rph_pkg::MaxLen)) begin
                st_d    = rph_pkg::StFull;
                valid_d = 1'b1;
              end else begin
                state_d = S_A_RD;
              end
            end
            rph_pkg::ReqQuery: begin
              if (left_pos_i > right_pos_i) begin
                valid_d = 1'b1;
              end else if (rph_pkg::LenW'(right_pos_i) >= len_q) begin
                st_d    = rph_pkg::StBeyond;
                valid_d = 1'b1;
              end else begin
                state_d = S_Q_RD1;
              end
            end
            rph_pkg::ReqClear: begin
              len_d   = '0;
              valid_d = 1'b1;
            end
            default: valid_d = 1'b1;
          endcase
        end
      end
      S_A_RD: begin
        // The empty string has implicit hash zero and power one.
        a_d     = (len_q == '0) ? '0 : hash_rd;
        b_d     = (len_q == '0) ? rph_pkg::DataW'(1) : power_rd;
        state_d = S_A_RY;
      end
      S_A_RY: begin
        if (eng_done) begin
          k_d        = eng_res;
          launched_d = 1'b0;
          state_d    = S_A_MH;
        end
      end
      S_A_MH: begin
        if (eng_done) begin
          h_d        = eng_res;
          launched_d = 1'b0;
          state_d    = S_A_RC;
        end
      end
      S_A_RC: begin
        if (eng_done) begin
          c_d        = eng_res;
          launched_d = 1'b0;
          state_d    = S_A_ADD;
        end
      end
      S_A_ADD: begin
        h_d = (add_sum >= {1'b0, m_eff}) ? rph_pkg::DataW'(add_sum - {1'b0, m_eff})
                                         : add_sum[rph_pkg::DataW-1:0];
        state_d = S_A_MP;
      end
      S_A_MP: begin
        if (eng_done) begin
          launched_d = 1'b0;
          state_d    = S_A_WR;
        end
      end
      S_A_WR: begin
        // The power is still held in the multiplier result here.
        wr.we   = 1'b1;
        len_d   = len_q + 1'b1;
        res_d   = h_q;
        valid_d = 1'b1;
        state_d = S_IDLE;
      end
      S_Q_RD1: begin
        a_d     = hash_rd;
        b_d     = power_rd;
        state_d = S_Q_RD2;
      end
      S_Q_RD2: begin
        c_d     = (lp_q == '0) ? '0 : hash_rd;
        state_d = S_Q_RH;
      end
      S_Q_RH: begin
        if (eng_done) begin
          a_d        = eng_res;
          launched_d = 1'b0;
          state_d    = S_Q_RP;
        end
      end
      S_Q_RP: begin
        if (eng_done) begin
          b_d        = eng_res;
          launched_d = 1'b0;
          state_d    = S_Q_MS;
        end
      end
      S_Q_MS: begin
        if (eng_done) begin
          h_d        = eng_res;
          launched_d = 1'b0;
          state_d    = S_Q_FIN;
        end
      end
      S_Q_FIN: begin
        res_d   = (a_q >= h_q) ? (a_q - h_q) : (a_q + (m_eff - h_q));
        valid_d = 1'b1;
        state_d = S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= S_IDLE;
      modulus_q  <= rph_pkg::ModulusReset;
      radix_q    <= rph_pkg::RadixReset;
      len_q      <= '0;
      launched_q <= 1'b0;
      valid_q    <= 1'b0;
    end else begin
      state_q    <= state_d;
      modulus_q  <= modulus_d;
      radix_q    <= radix_d;
      len_q      <= len_d;
      launched_q <= launched_d;
      valid_q    <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    res_q  <= res_d;
    st_q   <= st_d;
    char_q <= char_d;
    lp_q   <= lp_d;
    a_q    <= a_d;
    b_q    <= b_d;
    c_q    <= c_d;
    h_q    <= h_d;
    k_q    <= k_d;
  end

  rph_mulmod u_mulmod (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .go_i     (eng_go),
    .x_i      (eng_x),
    .y_i      (eng_y),
    .m_i      (m_eff),
    .done_o   (eng_done),
    .result_o (eng_res)
  );

  rph_store u_store (
    .clk_i        (clk_i),
    .wr_i         (wr),
    .hash_addr_i  (hash_addr),
    .power_addr_i (power_addr),
    .hash_o       (hash_rd),
    .power_o      (power_rd)
  );

  assign valid_o      = valid_q;
  assign hash_value_o = res_q;
  assign status_o     = st_q;

endmodule
